@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/bsa_pkg.sv @@
// ---------------------------------------------------------------------------
// bsa_pkg
// Types, widths, constants and tables for the board square to arm angle block.
// ---------------------------------------------------------------------------
package bsa_pkg;

    // Field widths
    localparam int POS_W   = 16;   // signed position, 2^-16 m
    localparam int LEN_W   = 15;   // unsigned length register
    localparam int ANG_W   = 16;   // signed angle, 2^-13 rad
    localparam int IDX_W   = 3;    // file / rank index
    localparam int WP_W    = 3;    // waypoint code
    localparam int CFG_W   = 16;   // configuration data
    localparam int CFGI_W  = 3;    // configuration index

    // Square root datapath
    localparam int SQ_W    = 31;   // x*x, y*y
    localparam int NSUM_W  = 32;   // x*x + y*y
    localparam int RAD_W   = 48;   // (x*x + y*y) << 16
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;

    // CORDIC datapath
    localparam int CV_W    = 28;   // vector components, 2^-24 m
    localparam int CZ_W    = 34;   // angle accumulator, 2^-30 rad
    localparam int ATAN_STEPS       = 24;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int CORDIC_STEPS =
        (ANGLE_ITERATIONS < ATAN_STEPS) ? ANGLE_ITERATIONS : ATAN_STEPS;
    localparam int STEP_W  = $clog2(ATAN_STEPS);

    localparam logic signed [CZ_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] ELBOW_FIXED = 16'sd4096;

    // Waypoint codes
    localparam logic [WP_W-1:0] WP_LIFT_START = 3'd0;
    localparam logic [WP_W-1:0] WP_SOURCE     = 3'd1;
    localparam logic [WP_W-1:0] WP_LIFT_MID   = 3'd2;
    localparam logic [WP_W-1:0] WP_TARGET     = 3'd3;
    localparam logic [WP_W-1:0] WP_LIFT_END   = 3'd4;

    // Configuration register indexes
    typedef enum logic [CFGI_W-1:0] {
        REG_SQUARE_PITCH = 3'd0,
        REG_CORNER_X     = 3'd1,
        REG_CORNER_Y     = 3'd2,
        REG_GRIP_HEIGHT  = 3'd3,
        REG_LIFT_HEIGHT  = 3'd4,
        REG_WRIST_ROLL   = 3'd5,
        REG_WRIST_PITCH  = 3'd6,
        REG_WRIST_YAW    = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0]        RST_SQUARE_PITCH = 15'd3277;
    localparam logic signed [POS_W-1:0] RST_CORNER_X     = -16'sd14336;
    localparam logic signed [POS_W-1:0] RST_CORNER_Y     = -16'sd14336;
    localparam logic [LEN_W-1:0]        RST_GRIP_HEIGHT  = 15'd2032;
    localparam logic [LEN_W-1:0]        RST_LIFT_HEIGHT  = 15'd9830;
    localparam logic signed [ANG_W-1:0] RST_WRIST_ROLL   = 16'sd0;
    localparam logic signed [ANG_W-1:0] RST_WRIST_PITCH  = 16'sd12861;
    localparam logic signed [ANG_W-1:0] RST_WRIST_YAW    = 16'sd0;

    // Request on the input channel: one move
    typedef struct packed {
        logic [IDX_W-1:0] from_file;
        logic [IDX_W-1:0] from_rank;
        logic [IDX_W-1:0] to_file;
        logic [IDX_W-1:0] to_rank;
    } in_t;

    // Request on the output channel: one waypoint
    typedef struct packed {
        logic signed [ANG_W-1:0] base_angle;
        logic signed [ANG_W-1:0] shoulder_angle;
        logic signed [ANG_W-1:0] elbow_angle;
        logic signed [ANG_W-1:0] roll_out;
        logic signed [ANG_W-1:0] pitch_out;
        logic signed [ANG_W-1:0] yaw_out;
        logic [WP_W-1:0]         waypoint;
        logic                    last;
    } out_t;

    // Board geometry registers seen by the sequencer
    typedef struct packed {
        logic [LEN_W-1:0]        square_pitch;
        logic signed [POS_W-1:0] corner_x;
        logic signed [POS_W-1:0] corner_y;
        logic [LEN_W-1:0]        grip_height;
        logic [LEN_W-1:0]        lift_height;
    } geom_t;

    // Sequencer status
    typedef struct packed {
        logic            busy;
        logic [WP_W-1:0] cnt;
    } issue_stat_t;

    // One waypoint position
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [LEN_W-1:0]        z;
        logic [WP_W-1:0]         wp;
    } pt_t;

    // Square stage
    typedef struct packed {
        logic [SQ_W-1:0] xsq;
        logic [SQ_W-1:0] ysq;
        pt_t             pt;
    } sq_t;

    // Square root cell token
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        pt_t               pt;
    } sqrt_tok_t;

    // CORDIC cell token: base lane and shoulder lane
    typedef struct packed {
        logic signed [CV_W-1:0] bx;
        logic signed [CV_W-1:0] by;
        logic signed [CZ_W-1:0] bz;
        logic                   bzero;
        logic signed [CV_W-1:0] sx;
        logic signed [CV_W-1:0] sy;
        logic signed [CZ_W-1:0] sz;
        logic                   szero;
        logic [WP_W-1:0]        wp;
    } cordic_tok_t;

    // atan(2^-i) in 2^-30 rad, truncated
    function automatic logic signed [CZ_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:    v = 34'h0_3243F6A8;
            5'd1:    v = 34'h0_1DAC6705;
            5'd2:    v = 34'h0_0FADBAFC;
            5'd3:    v = 34'h0_07F56EA6;
            5'd4:    v = 34'h0_03FEAB76;
            5'd5:    v = 34'h0_01FFD55B;
            5'd6:    v = 34'h0_00FFFAAA;
            5'd7:    v = 34'h0_007FFF55;
            5'd8:    v = 34'h0_003FFFEA;
            5'd9:    v = 34'h0_001FFFFD;
            5'd10:   v = 34'h0_000FFFFF;
            5'd11:   v = 34'h0_0007FFFF;
            5'd12:   v = 34'h0_0003FFFF;
            5'd13:   v = 34'h0_0001FFFF;
            5'd14:   v = 34'h0_0000FFFF;
            5'd15:   v = 34'h0_00007FFF;
            5'd16:   v = 34'h0_00003FFF;
            5'd17:   v = 34'h0_00001FFF;
            5'd18:   v = 34'h0_00000FFF;
            5'd19:   v = 34'h0_000007FF;
            5'd20:   v = 34'h0_000003FF;
            5'd21:   v = 34'h0_000001FF;
            5'd22:   v = 34'h0_000000FF;
            5'd23:   v = 34'h0_0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a 2^-30 rad angle to 2^-13 rad, halves away from zero
    function automatic logic signed [ANG_W-1:0] round_angle(input logic signed [CZ_W-1:0] z);
        logic signed [CZ_W:0] zw;
        logic [CZ_W:0]        mag;
        logic [CZ_W:0]        q;
        zw  = (CZ_W+1)'(z);
        mag = zw[CZ_W] ? (CZ_W+1)'(-zw) : (CZ_W+1)'(zw);
        q   = (mag + (CZ_W+1)'(65536)) >> 17;
        return zw[CZ_W] ? ANG_W'(-q) : ANG_W'(q);
    endfunction

endpackage

@@ rtl/board_square_to_arm_angles.sv @@
// ---------------------------------------------------------------------------
// board_square_to_arm_angles
// Chess move to arm joint angles: five waypoints per move.
// ---------------------------------------------------------------------------
// Each move request yields five waypoint requests (lift, source, lift,
// target, lift), one per cycle while the pipeline advances, and a new move is
// taken in the cycle its predecessor's last waypoint is issued. The rate is
// set by the waypoint sequencer, which issues one position per cycle into
// a single pipeline: two stages of squaring and summing, a row of 24 square
// root cells (one root bit each), one preparation stage, a row of
// ANGLE_ITERATIONS (16) CORDIC cells that turn the base and shoulder vectors
// side by side, and the output register. The whole pipeline holds while the
// output register is full and stalled. Configuration writes belong to idle
// periods; the wrist angles are read at the output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module board_square_to_arm_angles (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bsa_pkg::CFGI_W-1:0]   cfg_index,
    input  logic [bsa_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bsa_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bsa_pkg::out_t                out_data
);

    localparam int SQRT_CELLS = bsa_pkg::ROOT_W;
    localparam int CORD_CELLS = bsa_pkg::CORDIC_STEPS;

    // Configuration registers
    logic [bsa_pkg::LEN_W-1:0]        square_pitch_reg;
    logic signed [bsa_pkg::POS_W-1:0] corner_x_reg;
    logic signed [bsa_pkg::POS_W-1:0] corner_y_reg;
    logic [bsa_pkg::LEN_W-1:0]        grip_height_reg;
    logic [bsa_pkg::LEN_W-1:0]        lift_height_reg;
    logic signed [bsa_pkg::ANG_W-1:0] wrist_roll_reg;
    logic signed [bsa_pkg::ANG_W-1:0] wrist_pitch_reg;
    logic signed [bsa_pkg::ANG_W-1:0] wrist_yaw_reg;
    bsa_pkg::geom_t                   geom;

    // Pipeline
    logic                             adv;
    logic                             pt_valid;
    bsa_pkg::pt_t                     pt;
    bsa_pkg::issue_stat_t             stat;
    logic                             sq_valid_reg;
    bsa_pkg::sq_t                     sq_reg, sq_next;
    logic signed [31:0]               xx, yy;
    logic                             sum_valid_reg;
    bsa_pkg::sqrt_tok_t               sum_reg, sum_next;
    logic [bsa_pkg::NSUM_W-1:0]       nsum;
    logic                             sqrt_valid [0:SQRT_CELLS];
    bsa_pkg::sqrt_tok_t               sqrt_tok   [0:SQRT_CELLS];
    logic                             prep_valid_reg;
    bsa_pkg::cordic_tok_t             prep_reg, prep_next;
    logic signed [bsa_pkg::CV_W-1:0]  x8, y8;
    bsa_pkg::pt_t                     spt;
    logic                             cord_valid [0:CORD_CELLS];
    bsa_pkg::cordic_tok_t             cord_tok   [0:CORD_CELLS];
    logic                             out_valid_reg;
    bsa_pkg::out_t                    out_reg, out_next;

    // Check terms
    logic                             out_lift;
    logic                             wp_ok;
    logic                             in_take;
    logic                             seq_end;
    logic                             seq_start;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_pitch_reg <= bsa_pkg::RST_SQUARE_PITCH;
            corner_x_reg     <= bsa_pkg::RST_CORNER_X;
            corner_y_reg     <= bsa_pkg::RST_CORNER_Y;
            grip_height_reg  <= bsa_pkg::RST_GRIP_HEIGHT;
            lift_height_reg  <= bsa_pkg::RST_LIFT_HEIGHT;
            wrist_roll_reg   <= bsa_pkg::RST_WRIST_ROLL;
            wrist_pitch_reg  <= bsa_pkg::RST_WRIST_PITCH;
            wrist_yaw_reg    <= bsa_pkg::RST_WRIST_YAW;
        end
        else if (cfg_we)
        begin
            unique case (bsa_pkg::cfg_reg_t'(cfg_index))
                bsa_pkg::REG_SQUARE_PITCH: square_pitch_reg <= cfg_data[bsa_pkg::LEN_W-1:0];
                bsa_pkg::REG_CORNER_X:     corner_x_reg     <= cfg_data;
                bsa_pkg::REG_CORNER_Y:     corner_y_reg     <= cfg_data;
                bsa_pkg::REG_GRIP_HEIGHT:  grip_height_reg  <= cfg_data[bsa_pkg::LEN_W-1:0];
                bsa_pkg::REG_LIFT_HEIGHT:  lift_height_reg  <= cfg_data[bsa_pkg::LEN_W-1:0];
                bsa_pkg::REG_WRIST_ROLL:   wrist_roll_reg   <= cfg_data;
                bsa_pkg::REG_WRIST_PITCH:  wrist_pitch_reg  <= cfg_data;
                bsa_pkg::REG_WRIST_YAW:    wrist_yaw_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign geom.square_pitch = square_pitch_reg;
    assign geom.corner_x     = corner_x_reg;
    assign geom.corner_y     = corner_y_reg;
    assign geom.grip_height  = grip_height_reg;
    assign geom.lift_height  = lift_height_reg;

    // Hold the whole pipeline while the output request is stalled
    assign adv = !out_valid_reg || !out_stall;

    // Waypoint sequencer
    bsa_issue u_issue (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .geom     (geom),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .pt_valid (pt_valid),
        .pt       (pt),
        .stat     (stat)
    );

    // Square x and y
    always_comb
    begin
        xx         = 32'(pt.x) * 32'(pt.x);
        yy         = 32'(pt.y) * 32'(pt.y);
        sq_next.xsq = xx[bsa_pkg::SQ_W-1:0];
        sq_next.ysq = yy[bsa_pkg::SQ_W-1:0];
        sq_next.pt  = pt;
    end

    // Sum the squares and scale by 2^16 for the root
    always_comb
    begin
        nsum          = {1'b0, sq_reg.xsq} + {1'b0, sq_reg.ysq};
        sum_next.rad  = {nsum, {(bsa_pkg::RAD_W - bsa_pkg::NSUM_W){1'b0}}};
        sum_next.rem  = '0;
        sum_next.root = '0;
        sum_next.pt   = sq_reg.pt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg   <= 1'b0;
            sum_valid_reg  <= 1'b0;
            prep_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg   <= pt_valid;
            sum_valid_reg  <= sq_valid_reg;
            prep_valid_reg <= sqrt_valid[SQRT_CELLS];
            out_valid_reg  <= cord_valid[CORD_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
            prep_reg <= prep_next;
            out_reg  <= out_next;
        end
    end

    // Square root cells
    assign sqrt_valid[0] = sum_valid_reg;
    assign sqrt_tok[0]   = sum_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        bsa_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sqrt_valid[i]),
            .in_tok    (sqrt_tok[i]),
            .out_valid (sqrt_valid[i+1]),
            .out_tok   (sqrt_tok[i+1])
        );
    end

    // Build both vectors; pre-rotate a base vector in the left half-plane
    always_comb
    begin
        spt = sqrt_tok[SQRT_CELLS].pt;
        x8  = {{(bsa_pkg::CV_W - bsa_pkg::POS_W - 8){spt.x[bsa_pkg::POS_W-1]}}, spt.x, 8'b0};
        y8  = {{(bsa_pkg::CV_W - bsa_pkg::POS_W - 8){spt.y[bsa_pkg::POS_W-1]}}, spt.y, 8'b0};
        prep_next.bzero = (spt.x == '0) && (spt.y == '0);
        if (x8 < 0)
        begin
            if (y8 >= 0)
            begin
                prep_next.bx = y8;
                prep_next.by = -x8;
                prep_next.bz = bsa_pkg::HALF_PI_Q30;
            end
            else
            begin
                prep_next.bx = -y8;
                prep_next.by = x8;
                prep_next.bz = -bsa_pkg::HALF_PI_Q30;
            end
        end
        else
        begin
            prep_next.bx = x8;
            prep_next.by = y8;
            prep_next.bz = '0;
        end
        prep_next.sx    = bsa_pkg::CV_W'(sqrt_tok[SQRT_CELLS].root);
        prep_next.sy    = bsa_pkg::CV_W'({spt.z, 8'b0});
        prep_next.sz    = '0;
        prep_next.szero = (sqrt_tok[SQRT_CELLS].root == '0) && (spt.z == '0);
        prep_next.wp    = spt.wp;
    end

    // CORDIC cells
    assign cord_valid[0] = prep_valid_reg;
    assign cord_tok[0]   = prep_reg;

    for (genvar i = 0; i < CORD_CELLS; i++)
    begin : g_cordic
        bsa_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .step      (bsa_pkg::STEP_W'(i)),
            .in_valid  (cord_valid[i]),
            .in_tok    (cord_tok[i]),
            .out_valid (cord_valid[i+1]),
            .out_tok   (cord_tok[i+1])
        );
    end

    // Round the angles and assemble the waypoint
    always_comb
    begin
        out_next.base_angle     = cord_tok[CORD_CELLS].bzero ? '0
                                : bsa_pkg::round_angle(cord_tok[CORD_CELLS].bz);
        out_next.shoulder_angle = cord_tok[CORD_CELLS].szero ? '0
                                : bsa_pkg::round_angle(cord_tok[CORD_CELLS].sz);
        out_next.elbow_angle    = bsa_pkg::ELBOW_FIXED;
        out_next.roll_out       = wrist_roll_reg;
        out_next.pitch_out      = wrist_pitch_reg;
        out_next.yaw_out        = wrist_yaw_reg;
        out_next.waypoint       = cord_tok[CORD_CELLS].wp;
        out_next.last           = (cord_tok[CORD_CELLS].wp == bsa_pkg::WP_LIFT_END);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Terms for the checks
    assign out_lift  = out_valid && ((out_data.waypoint == bsa_pkg::WP_LIFT_START)
                                  || (out_data.waypoint == bsa_pkg::WP_LIFT_MID)
                                  || (out_data.waypoint == bsa_pkg::WP_LIFT_END));
    assign wp_ok     = (out_data.waypoint <= bsa_pkg::WP_LIFT_END);
    assign in_take   = in_valid && !in_stall;
    assign seq_end   = !stat.busy || (stat.cnt == bsa_pkg::WP_LIFT_END);
    assign seq_start = stat.busy && (stat.cnt == bsa_pkg::WP_LIFT_START);

    // Checks
    `ASSERT_IMPLY(a_lift_on_axis, clk, rst_n, out_lift, out_data.base_angle == '0, "lift off axis")
    `ASSERT_IMPLY(a_wp_range, clk, rst_n, out_valid, wp_ok, "waypoint code out of range")
    `ASSERT_IMPLY(a_take_at_end, clk, rst_n, in_take, seq_end, "move taken mid sequence")
    `ASSERT_NEXT(a_start_seq, clk, rst_n, in_take, seq_start, "move did not start at lift")

endmodule

@@ rtl/bsa_issue.sv @@
// ---------------------------------------------------------------------------
// bsa_issue
// Holds one move and issues its five waypoint positions, one per cycle while the pipeline advances.
// ---------------------------------------------------------------------------
module bsa_issue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  bsa_pkg::geom_t       geom,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bsa_pkg::in_t         in_data,
    output logic                 pt_valid,
    output bsa_pkg::pt_t         pt,
    output bsa_pkg::issue_stat_t stat
);

    logic                        busy_reg, busy_next;
    logic [bsa_pkg::WP_W-1:0]    cnt_reg, cnt_next;
    bsa_pkg::in_t                move_reg;
    logic                        pt_valid_reg;
    bsa_pkg::pt_t                pt_reg, pt_next;
    logic                        last_issue;
    logic                        accept;
    logic [bsa_pkg::IDX_W-1:0]   file_sel, rank_sel;
    logic [17:0]                 prod_x, prod_y;
    logic signed [18:0]          sum_x, sum_y;
    logic signed [bsa_pkg::POS_W-1:0] sat_x, sat_y;

    // Take a new move when idle or in the cycle the last waypoint of the old one goes out
    always_comb
    begin
        last_issue = busy_reg && (cnt_reg == bsa_pkg::WP_LIFT_END) && adv;
        in_stall   = busy_reg && !last_issue;
        accept     = in_valid && !in_stall;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg && adv)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        if (last_issue)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = bsa_pkg::WP_LIFT_START;
        end
    end

    // Square centre of the current waypoint, saturated to 16 bits
    always_comb
    begin
        if (cnt_reg == bsa_pkg::WP_TARGET)
        begin
            file_sel = move_reg.to_file;
            rank_sel = move_reg.to_rank;
        end
        else
        begin
            file_sel = move_reg.from_file;
            rank_sel = move_reg.from_rank;
        end
        prod_x = 18'(file_sel) * 18'(geom.square_pitch);
        prod_y = 18'(rank_sel) * 18'(geom.square_pitch);
        sum_x  = 19'(geom.corner_x) + signed'({1'b0, prod_x});
        sum_y  = 19'(geom.corner_y) + signed'({1'b0, prod_y});

        if (sum_x > 19'sd32767)
            sat_x = 16'sh7FFF;
        else if (sum_x < -19'sd32768)
            sat_x = 16'sh8000;
        else
            sat_x = sum_x[15:0];

        if (sum_y > 19'sd32767)
            sat_y = 16'sh7FFF;
        else if (sum_y < -19'sd32768)
            sat_y = 16'sh8000;
        else
            sat_y = sum_y[15:0];
    end

    // Pick lift pose or square position
    always_comb
    begin
        pt_next.wp = cnt_reg;
        unique case (cnt_reg)
            bsa_pkg::WP_SOURCE, bsa_pkg::WP_TARGET:
            begin
                pt_next.x = sat_x;
                pt_next.y = sat_y;
                pt_next.z = geom.grip_height;
            end
            default:
            begin
                pt_next.x = '0;
                pt_next.y = '0;
                pt_next.z = geom.lift_height;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= bsa_pkg::WP_LIFT_START;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (adv)
            begin
                pt_valid_reg <= busy_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            move_reg <= in_data;
        end
        if (adv)
        begin
            pt_reg <= pt_next;
        end
    end

    assign pt_valid  = pt_valid_reg;
    assign pt        = pt_reg;
    assign stat.busy = busy_reg;
    assign stat.cnt  = cnt_reg;

endmodule

@@ rtl/bsa_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// bsa_sqrt_cell
// One digit of the integer square root: brings in two radicand bits and
// settles one root bit, then hands the token to the next cell.
// ---------------------------------------------------------------------------
module bsa_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  bsa_pkg::sqrt_tok_t in_tok,
    output logic               out_valid,
    output bsa_pkg::sqrt_tok_t out_tok
);

    logic                          valid_reg;
    bsa_pkg::sqrt_tok_t            tok_reg, tok_next;
    logic [bsa_pkg::REM_W+1:0]     pair;
    logic [bsa_pkg::REM_W+1:0]     trial;

    // Try to subtract 4*root + 1 from the extended remainder
    always_comb
    begin
        tok_next    = in_tok;
        pair        = {in_tok.rem, in_tok.rad[bsa_pkg::RAD_W-1 -: 2]};
        trial       = {{(bsa_pkg::REM_W - bsa_pkg::ROOT_W){1'b0}}, in_tok.root, 2'b01};
        tok_next.rad = in_tok.rad << 2;
        if (pair >= trial)
        begin
            tok_next.rem  = bsa_pkg::REM_W'(pair - trial);
            tok_next.root = {in_tok.root[bsa_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            tok_next.rem  = bsa_pkg::REM_W'(pair);
            tok_next.root = {in_tok.root[bsa_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the token
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

@@ rtl/bsa_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// bsa_cordic_cell
// One CORDIC vectoring step on the base and the shoulder vector.
// ---------------------------------------------------------------------------
module bsa_cordic_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [bsa_pkg::STEP_W-1:0]   step,
    input  logic                         in_valid,
    input  bsa_pkg::cordic_tok_t         in_tok,
    output logic                         out_valid,
    output bsa_pkg::cordic_tok_t         out_tok
);

    logic                           valid_reg;
    bsa_pkg::cordic_tok_t           tok_reg, tok_next;
    logic signed [bsa_pkg::CZ_W-1:0] atan;
    logic signed [bsa_pkg::CV_W-1:0] bdx, bdy, sdx, sdy;

    // Rotate each vector toward the x axis and track the angle
    always_comb
    begin
        tok_next = in_tok;
        atan = bsa_pkg::atan_q30(step);
        bdx  = in_tok.by >>> step;
        bdy  = in_tok.bx >>> step;
        sdx  = in_tok.sy >>> step;
        sdy  = in_tok.sx >>> step;

        if (in_tok.by > 0)
        begin
            tok_next.bx = in_tok.bx + bdx;
            tok_next.by = in_tok.by - bdy;
            tok_next.bz = in_tok.bz + atan;
        end
        else
        begin
            tok_next.bx = in_tok.bx - bdx;
            tok_next.by = in_tok.by + bdy;
            tok_next.bz = in_tok.bz - atan;
        end

        if (in_tok.sy > 0)
        begin
            tok_next.sx = in_tok.sx + sdx;
            tok_next.sy = in_tok.sy - sdy;
            tok_next.sz = in_tok.sz + atan;
        end
        else
        begin
            tok_next.sx = in_tok.sx - sdx;
            tok_next.sy = in_tok.sy + sdy;
            tok_next.sz = in_tok.sz - atan;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the token
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

@@ verif/board_square_to_arm_angles_tb.sv @@
// ---------------------------------------------------------------------------
// board_square_to_arm_angles_tb
// Self-checking bench for the move to arm angle block. Each accepted move
// request is expanded by a local fixed-point model into its five waypoint
// requests (square mapping with saturation, integer square root, CORDIC
// vectoring). Every waypoint leaving the block is compared field by field
// against the oldest prediction. Board settings are rewritten between
// phases; both channels see random gaps and stalls, plus one long
// output hold-off that backs the pipeline up into the input channel.
// ---------------------------------------------------------------------------
module board_square_to_arm_angles_tb;

    localparam int       LIMIT_CYCLES  = 600000;
    localparam int       SETTLE_CYCLES = 29 + bsa_pkg::ANGLE_ITERATIONS + 10;
    localparam longint   QUARTER_TURN  = 64'sd1686629713;   // pi/2 in 2^-30 rad
    localparam int       ELBOW_Q13     = 4096;              // 0.5 rad
    localparam int       TABLE_STEPS   = 24;

    // Raw register words for one board setting
    typedef struct packed {
        logic [15:0] square_pitch;
        logic [15:0] corner_x;
        logic [15:0] corner_y;
        logic [15:0] grip_height;
        logic [15:0] lift_height;
        logic [15:0] wrist_roll;
        logic [15:0] wrist_pitch;
        logic [15:0] wrist_yaw;
    } board_setting_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [bsa_pkg::CFGI_W-1:0] cfg_index = '0;
    logic [bsa_pkg::CFG_W-1:0]  cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    bsa_pkg::in_t               in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    bsa_pkg::out_t              out_data;

    // atan(2^-i) in 2^-30 rad, truncated
    longint atan_table [0:TABLE_STEPS-1] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Local copy of the board registers, starting at reset values
    logic [14:0]        cur_pitch = 15'd3277;
    logic signed [15:0] cur_cx    = -16'sd14336;
    logic signed [15:0] cur_cy    = -16'sd14336;
    logic [14:0]        cur_grip  = 15'd2032;
    logic [14:0]        cur_lift  = 15'd9830;
    logic signed [15:0] cur_roll  = 16'sd0;
    logic signed [15:0] cur_wpitch = 16'sd12861;
    logic signed [15:0] cur_yaw   = 16'sd0;

    bsa_pkg::out_t pending_waypoints[$];
    int   error_count     = 0;
    int   checked_count   = 0;
    int   cycle_count     = 0;
    bit   idling_on       = 1'b1;
    int   hold_request    = 0;
    int   hold_left       = 0;
    int   run_left        = 0;

    board_square_to_arm_angles uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------
    // Fixed-point model
    // ---------------------------------------------------------------------

    function automatic longint sat_pos(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = n;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // atan2(y, x) by CORDIC vectoring, rounded to 2^-13 rad
    function automatic logic signed [15:0] cordic_angle(input longint x, input longint y);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        int     steps;
        int     i;
        if (x == 0 && y == 0)
            return 16'sd0;
        acc = 0;
        // Fold the left half plane onto the right one
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x   = y;
                y   = -t;
                acc = QUARTER_TURN;
            end
            else
            begin
                x   = -y;
                y   = t;
                acc = -QUARTER_TURN;
            end
        end
        steps = (bsa_pkg::ANGLE_ITERATIONS < TABLE_STEPS) ? bsa_pkg::ANGLE_ITERATIONS
                                                           : TABLE_STEPS;
        for (i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x   = x + dx;
                y   = y - dy;
                acc = acc + atan_table[i];
            end
            else
            begin
                x   = x - dx;
                y   = y + dy;
                acc = acc - atan_table[i];
            end
        end
        if (acc >= 0)
            return 16'((acc + 65536) >>> 17);
        return 16'(-((-acc + 65536) >>> 17));
    endfunction

    function automatic bsa_pkg::out_t waypoint_pose(input longint x, input longint y,
                                                    input longint z,
                                                    input logic [bsa_pkg::WP_W-1:0] wp);
        bsa_pkg::out_t   w;
        longint unsigned sumsq;
        longint          radius;
        sumsq            = longint'(x * x + y * y) << 16;
        radius           = longint'(int_sqrt(sumsq));
        w.base_angle     = cordic_angle(x * 256, y * 256);
        w.shoulder_angle = cordic_angle(radius, z * 256);
        w.elbow_angle    = 16'(ELBOW_Q13);
        w.roll_out       = cur_roll;
        w.pitch_out      = cur_wpitch;
        w.yaw_out        = cur_yaw;
        w.waypoint       = wp;
        w.last           = (wp == bsa_pkg::WP_LIFT_END);
        return w;
    endfunction

    // Expand one move into its five waypoints
    task automatic predict_move(input bsa_pkg::in_t mv);
        longint pitch;
        longint cx;
        longint cy;
        longint sx;
        longint sy;
        longint tx;
        longint ty;
        pitch = cur_pitch;
        cx    = cur_cx;
        cy    = cur_cy;
        sx    = sat_pos(cx + longint'(mv.from_file) * pitch);
        sy    = sat_pos(cy + longint'(mv.from_rank) * pitch);
        tx    = sat_pos(cx + longint'(mv.to_file) * pitch);
        ty    = sat_pos(cy + longint'(mv.to_rank) * pitch);
        pending_waypoints.push_back(waypoint_pose(0, 0, cur_lift, bsa_pkg::WP_LIFT_START));
        pending_waypoints.push_back(waypoint_pose(sx, sy, cur_grip, bsa_pkg::WP_SOURCE));
        pending_waypoints.push_back(waypoint_pose(0, 0, cur_lift, bsa_pkg::WP_LIFT_MID));
        pending_waypoints.push_back(waypoint_pose(tx, ty, cur_grip, bsa_pkg::WP_TARGET));
        pending_waypoints.push_back(waypoint_pose(0, 0, cur_lift, bsa_pkg::WP_LIFT_END));
    endtask

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------

    task automatic store_reg(input bsa_pkg::cfg_reg_t idx, input logic [15:0] val);
        case (idx)
            bsa_pkg::REG_SQUARE_PITCH: cur_pitch  = val[14:0];
            bsa_pkg::REG_CORNER_X:     cur_cx     = val;
            bsa_pkg::REG_CORNER_Y:     cur_cy     = val;
            bsa_pkg::REG_GRIP_HEIGHT:  cur_grip   = val[14:0];
            bsa_pkg::REG_LIFT_HEIGHT:  cur_lift   = val[14:0];
            bsa_pkg::REG_WRIST_ROLL:   cur_roll   = val;
            bsa_pkg::REG_WRIST_PITCH:  cur_wpitch = val;
            bsa_pkg::REG_WRIST_YAW:    cur_yaw    = val;
            default: ;
        endcase
    endtask

    task automatic write_reg(input bsa_pkg::cfg_reg_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        store_reg(idx, val);
    endtask

    // Write every register, then drop the enable
    task automatic apply_setting(input board_setting_t s);
        write_reg(bsa_pkg::REG_SQUARE_PITCH, s.square_pitch);
        write_reg(bsa_pkg::REG_CORNER_X, s.corner_x);
        write_reg(bsa_pkg::REG_CORNER_Y, s.corner_y);
        write_reg(bsa_pkg::REG_GRIP_HEIGHT, s.grip_height);
        write_reg(bsa_pkg::REG_LIFT_HEIGHT, s.lift_height);
        write_reg(bsa_pkg::REG_WRIST_ROLL, s.wrist_roll);
        write_reg(bsa_pkg::REG_WRIST_PITCH, s.wrist_pitch);
        write_reg(bsa_pkg::REG_WRIST_YAW, s.wrist_yaw);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic board_setting_t random_setting();
        board_setting_t s;
        s.square_pitch = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 6000));
        s.corner_x     = 16'($urandom_range(0, 65535));
        s.corner_y     = 16'($urandom_range(0, 65535));
        s.grip_height  = 16'($urandom_range(0, 65535));
        s.lift_height  = 16'($urandom_range(0, 65535));
        s.wrist_roll   = 16'($urandom_range(0, 65535));
        s.wrist_pitch  = 16'($urandom_range(0, 65535));
        s.wrist_yaw    = 16'($urandom_range(0, 65535));
        return s;
    endfunction

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------

    // No gap half the time, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_move(input logic [2:0] ff, input logic [2:0] fr,
                             input logic [2:0] tf, input logic [2:0] tr);
        bsa_pkg::in_t mv;
        int           gap;
        mv.from_file = ff;
        mv.from_rank = fr;
        mv.to_file   = tf;
        mv.to_rank   = tr;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // Offer the request and hold it until taken
        in_valid <= 1'b1;
        in_data  <= mv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_move(mv);
    endtask

    task automatic send_random_move();
        send_move(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_waypoints.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------------

    // Random stall runs, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            run_left  = 0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (run_left > 0)
                run_left--;
            else if (idling_on && $urandom_range(0, 2) == 0)
            begin
                run_left = pick_gap();
                out_stall <= 1'b1;
            end
            else
            begin
                run_left = $urandom_range(1, 8);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR waypoint %0d: %s", checked_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Compare each accepted waypoint with the oldest prediction
    always @(posedge clk)
    begin
        bsa_pkg::out_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_waypoints.size() == 0)
                report_mismatch("waypoint with no prediction pending");
            else
            begin
                want = pending_waypoints.pop_front();
                check_field("base_angle", 32'(out_data.base_angle),
                            32'(want.base_angle));
                check_field("shoulder_angle", 32'(out_data.shoulder_angle),
                            32'(want.shoulder_angle));
                check_field("elbow_angle", 32'(out_data.elbow_angle),
                            32'(want.elbow_angle));
                check_field("roll_out", 32'(out_data.roll_out), 32'(want.roll_out));
                check_field("pitch_out", 32'(out_data.pitch_out), 32'(want.pitch_out));
                check_field("yaw_out", 32'(out_data.yaw_out), 32'(want.yaw_out));
                check_field("waypoint", 32'(out_data.waypoint), 32'(want.waypoint));
                check_field("last", 32'(out_data.last), 32'(want.last));
            end
            checked_count++;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("board_square_to_arm_angles test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Board corners and the middle at reset settings
    task automatic test_reset_defaults();
        send_move(0, 0, 7, 7);
        send_move(7, 7, 0, 0);
        send_move(7, 0, 0, 7);
        send_move(0, 7, 7, 0);
        send_move(3, 4, 4, 3);
        release_input();
        wait_idle();
    endtask

    // Largest pitch and extreme corners push squares into saturation; masked
    // wide writes and wrist angles outside the nominal range
    task automatic test_saturation();
        board_setting_t s;
        s.square_pitch = 16'hFFFF;
        s.corner_x     = 16'h7FFF;
        s.corner_y     = 16'h8000;
        s.grip_height  = 16'hFFFF;
        s.lift_height  = 16'h0000;
        s.wrist_roll   = 16'h7FFF;
        s.wrist_pitch  = 16'h8000;
        s.wrist_yaw    = 16'(-25736);
        apply_setting(s);
        send_move(0, 0, 7, 7);
        send_move(7, 7, 0, 0);
        send_move(0, 7, 7, 0);
        release_input();
        wait_idle();
    endtask

    // Every pose collapses onto the origin: all angles of zero vectors
    task automatic test_zero_vectors();
        board_setting_t s;
        s.square_pitch = 16'd0;
        s.corner_x     = 16'd0;
        s.corner_y     = 16'd0;
        s.grip_height  = 16'd0;
        s.lift_height  = 16'd0;
        s.wrist_roll   = 16'(-25736);
        s.wrist_pitch  = 16'd25736;
        s.wrist_yaw    = 16'd0;
        apply_setting(s);
        send_move(0, 0, 0, 0);
        send_move(7, 7, 7, 7);
        release_input();
        wait_idle();
    endtask

    // Squares on the axes, in all quadrants but the first and at the origin
    task automatic test_axis_crossings();
        board_setting_t s;
        s.square_pitch = 16'd1000;
        s.corner_x     = 16'(-3000);
        s.corner_y     = 16'(-3000);
        s.grip_height  = 16'd2032;
        s.lift_height  = 16'h7FFF;
        s.wrist_roll   = 16'd25736;
        s.wrist_pitch  = 16'd1;
        s.wrist_yaw    = 16'd25736;
        apply_setting(s);
        send_move(0, 3, 3, 0);
        send_move(3, 7, 7, 3);
        send_move(0, 0, 3, 3);
        send_move(0, 7, 7, 0);
        release_input();
        wait_idle();
    endtask

    // Hold the output off long enough for the block to stall its input
    task automatic test_backpressure();
        int n;
        idling_on    = 1'b0;
        hold_request = 300;
        for (n = 0; n < 30; n++)
            send_random_move();
        release_input();
        wait_idle();
        idling_on = 1'b1;
    endtask

    // Random moves under random board settings; first phase without idling
    task automatic test_random_settings();
        int p;
        int n;
        for (p = 0; p < 5; p++)
        begin
            apply_setting(random_setting());
            idling_on = (p != 0);
            for (n = 0; n < 46; n++)
                send_random_move();
            release_input();
            wait_idle();
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_defaults();
        test_saturation();
        test_zero_vectors();
        test_axis_crossings();
        test_backpressure();
        test_random_settings();
        if (error_count == 0)
            $display("board_square_to_arm_angles test passed");
        else
            $display("board_square_to_arm_angles test failed");
        $finish;
    end

endmodule
